### rtl/lfu_pkg.sv
// Shared types and constants for the LFU key/value table.
// Used by lfu_ctrl, lfu_dp and lfu_cache_table; no dependencies.
package lfu_pkg;

	localparam int DATA_W = 32;
	localparam int CAP_W  = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_PUT = 1'b1;

	// controller -> datapath
	typedef struct packed {
		logic load;    // capture request, clear scan results
		logic scan;    // read one entry and advance the scan address
		logic update;  // commit the table change and register the result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_last;
	} stat_t;

endpackage

### rtl/lfu_ctrl.sv
// Sequencer for the LFU table: idle, entry scan, drain, update.
// Depends on lfu_pkg (cmd_t, stat_t).
module lfu_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  lfu_pkg::stat_t stat,
	output lfu_pkg::cmd_t  cmd,
	output logic           busy
);
	import lfu_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_LAST = 2'd2;
	localparam logic [1:0] S_UPD  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_nxt = S_SCAN;
			S_SCAN: if (stat.scan_last) state_nxt = S_LAST;
			S_LAST: state_nxt = S_UPD;
			S_UPD:  state_nxt = S_IDLE;
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign busy       = (state_q != S_IDLE);
	assign cmd.load   = (state_q == S_IDLE) && start;
	assign cmd.scan   = (state_q == S_SCAN);
	assign cmd.update = (state_q == S_UPD);

endmodule

### rtl/lfu_dp.sv
// Datapath of the LFU table: entry memory, recency ranks, scan accumulators,
// update logic, capacity register and result registers. Depends on lfu_pkg.
module lfu_dp #(
	parameter int ENTRIES    = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lfu_pkg::cmd_t                 cmd,
	output lfu_pkg::stat_t                stat,
	input  logic                          cfg_wr,
	input  logic [lfu_pkg::CAP_W-1:0]     cfg_data,
	input  logic                          func,
	input  logic signed [lfu_pkg::DATA_W-1:0] key,
	input  logic signed [lfu_pkg::DATA_W-1:0] value,
	output logic                          done,
	output logic                          hit,
	output logic signed [lfu_pkg::DATA_W-1:0] read_value,
	output logic                          evicted,
	output logic signed [lfu_pkg::DATA_W-1:0] evicted_key
);
	import lfu_pkg::*;

	localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int FILL_W = $clog2(ENTRIES + 1);
	localparam int WORD_W = 2 * DATA_W + COUNT_BITS;

	// entry word: {key, value, use count}
	logic [WORD_W-1:0]     mem [ENTRIES];
	logic [IDX_W-1:0]      age_q [ENTRIES];
	logic [ENTRIES-1:0]    valid_q;
	logic [FILL_W-1:0]     fill_q;
	logic [CAP_W-1:0]      cap_q;

	logic [IDX_W-1:0]      addr_q;
	logic                  func_q;
	logic [DATA_W-1:0]     key_q;
	logic [DATA_W-1:0]     val_q;

	// scan read stage
	logic                  rd_s1;
	logic [WORD_W-1:0]     word_s1;
	logic                  vld_s1;
	logic [IDX_W-1:0]      age_s1;
	logic [IDX_W-1:0]      idx_s1;

	// scan results
	logic                  hit_q;
	logic [IDX_W-1:0]      hidx_q;
	logic [DATA_W-1:0]     hval_q;
	logic [COUNT_BITS-1:0] hcnt_q;
	logic [IDX_W-1:0]      hage_q;
	logic                  vfound_q;
	logic [IDX_W-1:0]      vidx_q;
	logic [DATA_W-1:0]     vkey_q;
	logic [COUNT_BITS-1:0] vcnt_q;
	logic [IDX_W-1:0]      vage_q;
	logic                  ffound_q;
	logic [IDX_W-1:0]      fidx_q;

	logic [DATA_W-1:0]     key_s1;
	logic [DATA_W-1:0]     val_s1;
	logic [COUNT_BITS-1:0] cnt_s1;
	logic                  match_s1;
	logic                  better_s1;

	logic                  is_put;
	logic                  cap_nz;
	logic                  full;
	logic                  do_touch;
	logic                  do_ins;
	logic                  do_ev;
	logic [IDX_W-1:0]      ins_idx;
	logic [COUNT_BITS-1:0] cnt_inc;

	assign key_s1 = word_s1[WORD_W-1 -: DATA_W];
	assign val_s1 = word_s1[COUNT_BITS +: DATA_W];
	assign cnt_s1 = word_s1[COUNT_BITS-1:0];

	assign match_s1  = rd_s1 && vld_s1 && (key_s1 == key_q);
	// smaller count wins, older rank breaks a tie
	assign better_s1 = !vfound_q || (cnt_s1 < vcnt_q) ||
		((cnt_s1 == vcnt_q) && (age_s1 > vage_q));

	assign stat.scan_last = (addr_q == IDX_W'(ENTRIES - 1));

	assign is_put   = (func_q == FUNC_PUT);
	assign cap_nz   = (cap_q != '0);
	assign full     = (32'(fill_q) >= 32'(cap_q)) || (32'(fill_q) >= 32'(ENTRIES));
	assign do_touch = hit_q && (!is_put || cap_nz);
	assign do_ins   = is_put && cap_nz && !hit_q;
	assign do_ev    = do_ins && full && vfound_q;
	assign cnt_inc  = (hcnt_q == '1) ? hcnt_q : hcnt_q + COUNT_BITS'(1);

	always_comb begin
		if (do_ev && !(ffound_q && (fidx_q < vidx_q))) begin
			ins_idx = vidx_q;
		end else begin
			ins_idx = fidx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr) begin
			cap_q <= cfg_data;
		end
	end

	// request capture and scan address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
			rd_s1  <= 1'b0;
		end else begin
			rd_s1 <= cmd.scan;
			if (cmd.load) begin
				addr_q <= '0;
			end else if (cmd.scan && !stat.scan_last) begin
				addr_q <= addr_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			key_q  <= key;
			val_q  <= value;
		end
	end

	// entry memory: one read during the scan, one write at update
	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			word_s1 <= mem[addr_q];
			vld_s1  <= valid_q[addr_q];
			age_s1  <= age_q[addr_q];
			idx_s1  <= addr_q;
		end
		if (cmd.update && do_touch) begin
			mem[hidx_q] <= {key_q, (is_put ? val_q : hval_q), cnt_inc};
		end else if (cmd.update && do_ins) begin
			mem[ins_idx] <= {key_q, val_q, COUNT_BITS'(1)};
		end
	end

	// scan accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q    <= 1'b0;
			vfound_q <= 1'b0;
			ffound_q <= 1'b0;
		end else if (cmd.load) begin
			hit_q    <= 1'b0;
			vfound_q <= 1'b0;
			ffound_q <= 1'b0;
		end else if (rd_s1) begin
			if (match_s1) begin
				hit_q <= 1'b1;
			end
			if (vld_s1 && better_s1) begin
				vfound_q <= 1'b1;
			end
			if (!vld_s1) begin
				ffound_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (match_s1) begin
			hidx_q <= idx_s1;
			hval_q <= val_s1;
			hcnt_q <= cnt_s1;
			hage_q <= age_s1;
		end
		if (rd_s1 && vld_s1 && better_s1) begin
			vidx_q <= idx_s1;
			vkey_q <= key_s1;
			vcnt_q <= cnt_s1;
			vage_q <= age_s1;
		end
		if (rd_s1 && !vld_s1 && !ffound_q) begin
			fidx_q <= idx_s1;
		end
	end

	// recency ranks: each entry updates its own rank
	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (cmd.update && do_touch) begin
				if (IDX_W'(i) == hidx_q) begin
					age_q[i] <= '0;
				end else if (valid_q[i] && (age_q[i] < hage_q)) begin
					age_q[i] <= age_q[i] + IDX_W'(1);
				end
			end else if (cmd.update && do_ins) begin
				if (IDX_W'(i) == ins_idx) begin
					age_q[i] <= '0;
				end else if (valid_q[i]) begin
					if (do_ev && (age_q[i] > vage_q)) begin
						age_q[i] <= age_q[i];
					end else begin
						age_q[i] <= age_q[i] + IDX_W'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
		end else if (cmd.update && do_ins) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (IDX_W'(i) == ins_idx) begin
					valid_q[i] <= 1'b1;
				end else if (do_ev && (IDX_W'(i) == vidx_q)) begin
					valid_q[i] <= 1'b0;
				end
			end
			if (!do_ev) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	// result registers: zero outside the strobe cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done    <= 1'b0;
			hit     <= 1'b0;
			evicted <= 1'b0;
		end else begin
			done    <= cmd.update;
			hit     <= cmd.update && do_touch;
			evicted <= cmd.update && do_ev;
		end
	end

	always_ff @(posedge clk) begin
		read_value  <= (cmd.update && do_touch && !is_put) ? hval_q : '0;
		evicted_key <= (cmd.update && do_ev) ? vkey_q : '0;
	end

endmodule

### rtl/lfu_cache_table.sv
// Top level of the LFU key/value table with least-recent tie break.
// Instantiates lfu_ctrl and lfu_dp; depends on lfu_pkg.
//
// Usage:
//   Request: drive func/key/value with start; the request transfers at a
//   clock edge where start is high and busy is low. func 0 is a get, 1 a put.
//   Result: done pulses for one cycle with hit, read_value, evicted and
//   evicted_key; the receiver must take it in that cycle, it cannot stall.
//   Outside the done cycle the result ports read zero.
//   Capacity: cfg_ready is always high; a transfer on cfg_valid writes
//   cfg_data into the capacity register (values above ENTRIES act as
//   ENTRIES, zero turns puts into no-ops). Write it only while idle.
// Timing:
//   Each request scans the entry memory one entry per cycle, so busy stays
//   high through the scan, drain and update states; done rises in the
//   first cycle with busy low. A new request can transfer in the done cycle.
// Reset:
//   arst_n clears the table to empty and sets capacity to 16. No clearing
//   pass is needed; valid bits are flops.
module lfu_cache_table #(
	parameter int ENTRIES    = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              func,
	input  logic signed [lfu_pkg::DATA_W-1:0] key,
	input  logic signed [lfu_pkg::DATA_W-1:0] value,
	output logic                              done,
	output logic                              hit,
	output logic signed [lfu_pkg::DATA_W-1:0] read_value,
	output logic                              evicted,
	output logic signed [lfu_pkg::DATA_W-1:0] evicted_key,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [lfu_pkg::CAP_W-1:0]         cfg_data
);
	import lfu_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	lfu_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	lfu_dp #(
		.ENTRIES    (ENTRIES),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_wr      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.func        (func),
		.key         (key),
		.value       (value),
		.done        (done),
		.hit         (hit),
		.read_value  (read_value),
		.evicted     (evicted),
		.evicted_key (evicted_key)
	);

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy) && !$past(done))
		else $error("result strobe without a request in flight");

	a_flags_in_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		!done |-> !hit && !evicted)
		else $error("result flags outside the strobe cycle");

	a_evict_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		evicted |-> !hit)
		else $error("eviction on a hit");

endmodule
